@@ rtl/tdwf_pkg.sv @@
`default_nettype none
package tdwf_pkg;

  localparam int MAX_TILES  = 1024;
  localparam int TILE_WORDS = 32;
  localparam int WORD_W     = 16;
  localparam int TILE_W     = TILE_WORDS * WORD_W;
  localparam int TILE_AW    = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
  localparam int CNT_W      = $clog2(MAX_TILES + 1);
  localparam int MAP_IDX_W  = 10;

  typedef struct packed {
    logic [63:0] pixel_row;
    logic        new_image;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] word;
    logic        table_full;
    logic        last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_CMP,
    ST_EMIT,
    ST_MAP
  } state_t;

  typedef struct packed {
    logic load;
    logic hit;
    logic next;
    logic store;
    logic mark_full;
    logic emit_step;
    logic show_map;
  } ctl_cmd_t;

  typedef struct packed {
    logic tile_done;
    logic at_end;
    logic room;
    logic match;
    logic emit_last;
  } ctl_sts_t;

  function automatic logic [7:0] rev8(input logic [7:0] b);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = b[7 - i];
    end
    return r;
  endfunction

  function automatic logic [15:0] rev_word(input logic [15:0] w);
    return {rev8(w[15:8]), rev8(w[7:0])};
  endfunction

endpackage
`default_nettype wire

@@ rtl/tdwf_ram.sv @@
`default_nettype none
module tdwf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ rtl/tdwf_datapath.sv @@
`default_nettype none
module tdwf_datapath import tdwf_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire in_item_t in_data,
  input  wire ctl_cmd_t cmd,
  output ctl_sts_t      sts,
  output out_item_t     out_data
);

  logic [WORD_W-1:0] tile_r [TILE_WORDS];
  logic [2:0]        row_r;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  idx_r;
  logic [CNT_W-1:0]  res_idx_r;
  logic [4:0]        emit_cnt_r;
  logic              v_r, h_r, full_r;

  logic [2:0]        row_eff;
  logic [WORD_W-1:0] row_words [4];
  logic [TILE_W-1:0] tile_flat;
  logic [TILE_W-1:0] rd_data;
  logic              eq_d, eq_v, eq_h, eq_vh;

  assign row_eff = in_data.new_image ? 3'd0 : row_r;

  always_comb begin
    for (int p = 0; p < 4; p++) begin
      for (int x = 0; x < 8; x++) begin
        row_words[p][7 - x]  = in_data.pixel_row[8 * x + 2 * p];
        row_words[p][15 - x] = in_data.pixel_row[8 * x + 2 * p + 1];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < TILE_WORDS; k++) begin
      tile_flat[k * WORD_W +: WORD_W] = tile_r[k];
    end
  end

  always_comb begin
    logic [4:0]        kv;
    logic [WORD_W-1:0] s, sv;
    eq_d  = 1'b1;
    eq_v  = 1'b1;
    eq_h  = 1'b1;
    eq_vh = 1'b1;
    for (int k = 0; k < TILE_WORDS; k++) begin
      kv = 5'(k) ^ 5'd7;
      s  = rd_data[k * WORD_W +: WORD_W];
      sv = rd_data[32'(kv) * WORD_W +: WORD_W];
      eq_d  = eq_d  & (tile_r[k] == s);
      eq_v  = eq_v  & (tile_r[k] == sv);
      eq_h  = eq_h  & (tile_r[k] == rev_word(s));
      eq_vh = eq_vh & (tile_r[k] == rev_word(sv));
    end
  end

  tdwf_ram #(.WIDTH(TILE_W), .DEPTH(MAX_TILES)) u_store (
    .clk   (clk),
    .we    (cmd.store),
    .waddr (count_r[TILE_AW-1:0]),
    .wdata (tile_flat),
    .raddr (idx_r[TILE_AW-1:0]),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int p = 0; p < 4; p++) begin
        tile_r[{2'(p), row_eff}] <= row_words[p];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r   <= 3'd0;
      count_r <= '0;
    end else if (cmd.load) begin
      row_r <= row_eff + 3'd1;
      if (in_data.new_image) begin
        count_r <= '0;
      end
    end else if (cmd.store) begin
      count_r <= count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx_r <= '0;
    end else if (cmd.next) begin
      idx_r <= idx_r + CNT_W'(1);
    end
    if (cmd.hit) begin
      res_idx_r <= idx_r;
      full_r    <= 1'b0;
      v_r       <= !eq_d && (eq_v || (!eq_h && eq_vh));
      h_r       <= !eq_d && !eq_v;
    end else if (cmd.store) begin
      res_idx_r  <= count_r;
      full_r     <= 1'b0;
      v_r        <= 1'b0;
      h_r        <= 1'b0;
      emit_cnt_r <= 5'd0;
    end else if (cmd.mark_full) begin
      res_idx_r <= '0;
      full_r    <= 1'b1;
      v_r       <= 1'b0;
      h_r       <= 1'b0;
    end
    if (cmd.emit_step) begin
      emit_cnt_r <= emit_cnt_r + 5'd1;
    end
  end

  assign sts.tile_done = !in_data.new_image && (row_r == 3'd7);
  assign sts.at_end    = (idx_r >= count_r);
  assign sts.room      = (count_r < CNT_W'(MAX_TILES));
  assign sts.match     = eq_d || eq_v || eq_h || eq_vh;
  assign sts.emit_last = (emit_cnt_r == 5'd31);

  always_comb begin
    if (cmd.show_map) begin
      out_data.kind       = 1'b1;
      out_data.word       = {v_r, h_r, 4'b0000, MAP_IDX_W'(res_idx_r)};
      out_data.table_full = full_r;
      out_data.last       = 1'b1;
    end else begin
      out_data.kind       = 1'b0;
      out_data.word       = tile_r[emit_cnt_r];
      out_data.table_full = 1'b0;
      out_data.last       = 1'b0;
    end
  end

endmodule
`default_nettype wire

@@ rtl/tdwf_ctrl.sv @@
`default_nettype none
module tdwf_ctrl import tdwf_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire ctl_sts_t sts,
  output ctl_cmd_t      cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && sts.tile_done) state_nxt = ST_RD;
      end
      ST_RD: begin
        if (!sts.at_end) state_nxt = ST_CMP;
        else if (sts.room) state_nxt = ST_EMIT;
        else state_nxt = ST_MAP;
      end
      ST_CMP: begin
        state_nxt = sts.match ? ST_MAP : ST_RD;
      end
      ST_EMIT: begin
        if (out_ready && sts.emit_last) state_nxt = ST_MAP;
      end
      ST_MAP: begin
        if (out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_RD: begin
        if (sts.at_end) begin
          cmd.store     = sts.room;
          cmd.mark_full = !sts.room;
        end
      end
      ST_CMP: begin
        cmd.hit  = sts.match;
        cmd.next = !sts.match;
      end
      ST_EMIT: begin
        out_valid     = 1'b1;
        cmd.emit_step = out_ready;
      end
      ST_MAP: begin
        out_valid    = 1'b1;
        cmd.show_map = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/tile_dedup_with_flips.sv @@
// Rows that do not end a tile: accepted while idle, no output transaction.
// Tile end: the search visits each stored tile in turn, a read state (one registered read of
// the tile store per candidate) then a compare state, until a match or the stored count,
// then 33 transactions for a new tile or 1 for a match or a full table, one per cycle
// under out_ready. Synchronous active-low reset clears the row and tile counters and
// the controller; the tile store is not cleared and is read only below the stored count.
`default_nettype none
module tile_dedup_with_flips import tdwf_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  tdwf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tdwf_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

@@ rtl/tdwf_checker.sv @@
`default_nettype none
module tdwf_checker import tdwf_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output transaction dropped or changed while stalled");

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while a result is pending");

  a_data_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.kind |-> !out_data.last && !out_data.table_full)
    else $error("data word carries tilemap flags");

  a_full_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.table_full |-> out_data.kind && out_data.word == 16'h0000)
    else $error("table full entry not index 0 without flips");

  a_map_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.last |=> !out_valid)
    else $error("output continues after the tilemap entry");

endmodule

bind tile_dedup_with_flips tdwf_checker u_tdwf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire

@@ dv/tb_tile_dedup_with_flips.sv @@
`timescale 1ns / 1ps
module tb_tile_dedup_with_flips;
  import tdwf_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  tile_dedup_with_flips i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // shadow state of the packer
  logic [15:0] cur_words [TILE_WORDS];
  logic [15:0] uniq_words [MAX_TILES][TILE_WORDS];
  logic [2:0]  row_idx;
  int          uniq_cnt;

  out_item_t   exp_q [$];
  int          mismatches;
  int          unexpected;
  longint      cycles = 0;

  // directed rows; exp_map is the tilemap word where it is obvious, else -1
  typedef struct {
    logic [63:0] row;
    logic        ni;
    int          exp_map;
  } dir_row_t;

  function automatic logic [15:0] flip_bytes(logic [15:0] w);
    logic [15:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i]     = w[7 - i];
      r[8 + i] = w[15 - i];
    end
    return r;
  endfunction

  function automatic bit tile_hits(int t, bit vf, bit hf);
    logic [15:0] s;
    for (int p = 0; p < 4; p++) begin
      for (int y = 0; y < 8; y++) begin
        s = uniq_words[t][p * 8 + (vf ? 7 - y : y)];
        if (hf) s = flip_bytes(s);
        if (cur_words[p * 8 + y] != s) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  task automatic predict_row(input in_item_t it);
    logic [7:0] lo, hi, pix;
    out_item_t  o;
    bit         hit, v, h;
    int         idx;
    if (it.new_image) begin
      uniq_cnt = 0;
      row_idx  = 3'd0;
    end
    for (int p = 0; p < 4; p++) begin
      for (int x = 0; x < 8; x++) begin
        pix       = it.pixel_row[8 * x +: 8];
        lo[7 - x] = pix[2 * p];
        hi[7 - x] = pix[2 * p + 1];
      end
      cur_words[p * 8 + row_idx] = {hi, lo};
    end
    row_idx = row_idx + 3'd1;
    if (row_idx != 3'd0) return;
    hit = 1'b0; v = 1'b0; h = 1'b0; idx = 0;
    for (int t = 0; t < uniq_cnt && !hit; t++) begin
      if (tile_hits(t, 0, 0)) begin hit = 1; v = 0; h = 0; end
      else if (tile_hits(t, 1, 0)) begin hit = 1; v = 1; h = 0; end
      else if (tile_hits(t, 0, 1)) begin hit = 1; v = 0; h = 1; end
      else if (tile_hits(t, 1, 1)) begin hit = 1; v = 1; h = 1; end
      if (hit) idx = t;
    end
    o = '0;
    if (!hit && uniq_cnt < MAX_TILES) begin
      idx = uniq_cnt;
      for (int w = 0; w < TILE_WORDS; w++) begin
        uniq_words[idx][w] = cur_words[w];
        o.word = cur_words[w];
        exp_q.push_back(o);
      end
      uniq_cnt++;
    end else if (!hit) begin
      o.table_full = 1'b1;
    end
    o.kind = 1'b1;
    o.last = 1'b1;
    o.word = {v, h, 4'd0, idx[9:0]};
    exp_q.push_back(o);
  endtask

  task automatic send_row(input logic [63:0] row, input logic ni);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_data.pixel_row <= row;
    in_data.new_image <= ni;
    predict_row('{pixel_row: row, new_image: ni});
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic [63:0] rand_row(int mode);
    logic [63:0] r;
    r = {$urandom, $urandom};
    case (mode)
      0: r = r & 64'h0303_0303_0303_0303;
      1: r = {8{r[7:0]}};
      default: ;
    endcase
    return r;
  endfunction

  // out side: random stall, compare against queue
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (exp_q.size() == 0) begin
          unexpected++;
          if (mismatches + unexpected <= 10)
            $display("unexpected transaction %h", out_data);
        end else begin
          if (out_data.kind != exp_q[0].kind || out_data.word != exp_q[0].word ||
              out_data.table_full != exp_q[0].table_full ||
              out_data.last != exp_q[0].last) begin
            mismatches++;
            if (mismatches + unexpected <= 10)
              $display("mismatch: exp kind=%b word=%h full=%b last=%b, %s",
                       exp_q[0].kind, exp_q[0].word, exp_q[0].table_full,
                       exp_q[0].last,
                       $sformatf("got kind=%b word=%h full=%b last=%b",
                                 out_data.kind, out_data.word,
                                 out_data.table_full, out_data.last));
          end
          void'(exp_q.pop_front());
        end
      end
      if ($urandom_range(0, 49) == 0) out_ready <= 1'b0;
      else if ($urandom_range(0, 2) == 0) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(0, 4) != 0);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 64'd3_000_000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  dir_row_t dir_tbl [$];
  logic [63:0] t_rows [8];

  initial begin
    logic [63:0] r;
    int          m, reps;
    in_valid   = 1'b0;
    in_data    = '0;
    rst_n      = 1'b0;
    mismatches = 0;
    unexpected = 0;
    row_idx    = 3'd0;
    uniq_cnt   = 0;
    for (int w = 0; w < TILE_WORDS; w++) cur_words[w] = '0;

    // all zero tile -> index 0, then repeated -> same, then all ones -> index 1
    for (int i = 0; i < 8; i++) dir_tbl.push_back('{64'h0, i == 0, (i == 7) ? 16'h0000 : -1});
    for (int i = 0; i < 8; i++) dir_tbl.push_back('{64'h0, 1'b0, (i == 7) ? 16'h0000 : -1});
    for (int i = 0; i < 8; i++)
      dir_tbl.push_back('{64'hffff_ffff_ffff_ffff, 1'b0, (i == 7) ? 16'h0001 : -1});
    // one row of a tile left unfinished; the next new image row then arrives mid-tile
    dir_tbl.push_back('{64'h0123_4567_89ab_cdef, 1'b0, -1});

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tbl[k]) begin
      send_row(dir_tbl[k].row, dir_tbl[k].ni);
      if (dir_tbl[k].exp_map >= 0 && exp_q[$].word != dir_tbl[k].exp_map[15:0]) begin
        mismatches++;
        $display("tilemap prediction %h, table says %h", exp_q[$].word, dir_tbl[k].exp_map);
      end
    end

    // flipped variants of one random tile: direct, v, h, both
    for (int y = 0; y < 8; y++) t_rows[y] = {$urandom, $urandom};
    for (int f = 0; f < 4; f++) begin
      for (int y = 0; y < 8; y++) begin
        r = t_rows[(f & 1) ? 7 - y : y];
        if (f & 2) r = {r[7:0], r[15:8], r[23:16], r[31:24],
                        r[39:32], r[47:40], r[55:48], r[63:56]};
        send_row(r, (f == 0 && y == 0));
      end
    end

    // random: tiles, many repeats and rows mirrored at random to hit dedup
    reps = 0;
    while (reps < 290) begin
      m = $urandom_range(0, 9);
      if (m < 4) begin
        for (int y = 0; y < 8; y++) t_rows[y] = rand_row($urandom_range(0, 2));
      end
      for (int y = 0; y < 8; y++) begin
        r = t_rows[($urandom_range(0, 1) && m >= 4) ? 7 - y : y];
        if (m == 9 && y == 0) r = ~r;
        send_row(r, ($urandom_range(0, 120) == 0) && y != 0 ? 1'b1 : 1'b0);
        reps++;
        if (exp_q.size() == 0 && row_idx != 0 && $urandom_range(0, 60) == 0) break;
      end
    end
    in_valid <= 1'b0;

    while (exp_q.size() != 0) @(posedge clk);
    repeat (2 * MAX_TILES + 50) @(posedge clk);
    if (mismatches == 0 && unexpected == 0 && exp_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/tdwf_pkg.sv
rtl/tdwf_ram.sv
rtl/tdwf_datapath.sv
rtl/tdwf_ctrl.sv
rtl/tile_dedup_with_flips.sv
rtl/tdwf_checker.sv
dv/tb_tile_dedup_with_flips.sv
